### hdl/isiq_pkg.sv
// ----------------------------------------------------------------------------
// isiq_pkg
// Shared types and codes for the interval set block: request modes, result
// status codes and the control word broadcast along the cell row.
// ----------------------------------------------------------------------------
package isiq_pkg;

	// fixed port widths
	localparam int COORD_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd2;

	// operation applied by every cell in a cycle
	typedef enum logic [1:0] {
		CELL_IDLE,
		CELL_CMP,
		CELL_MERGE
	} cell_op_t;

	// control word broadcast to the row
	typedef struct packed {
		cell_op_t op;
		logic     ins_en;   // insert the new interval, shifting the tail right
		logic     mrg_en;   // first overlapping cell takes the union
	} cell_ctl_t;

endpackage

### hdl/isiq_cell.sv
// ----------------------------------------------------------------------------
// isiq_cell
// One slot of the sorted interval row. Compares its interval with the
// broadcast request, takes the new interval or its left neighbor on insert,
// and pulls its right neighbor in during merge compaction.
// ----------------------------------------------------------------------------
module isiq_cell #(
	parameter int IDX  = 0,
	parameter int CW   = 32,
	parameter int CNTW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  isiq_pkg::cell_ctl_t ctl,
	input  logic [CW-1:0]       s,
	input  logic [CW-1:0]       e,
	input  logic [CNTW-1:0]     count,
	// left neighbor
	input  logic [CW-1:0]       l_start,
	input  logic [CW-1:0]       l_end,
	input  logic                l_below,
	input  logic                l_ov,
	// right neighbor
	input  logic [CW-1:0]       r_start,
	input  logic [CW-1:0]       r_end,
	input  logic                r_ov_q,
	// own state and compare flags
	output logic [CW-1:0]       start_q,
	output logic [CW-1:0]       end_q,
	output logic                ov_q,
	output logic                below,
	output logic                ov,
	output logic                hit,
	output logic                ov_next
);
	import isiq_pkg::*;

	localparam logic [CNTW-1:0] IDX_C = CNTW'(IDX);

	logic          valid;
	logic          end_lt_s;
	logic          start_le_e;
	logic          head;
	logic          below_q;
	logic          hd_q;
	logic          after_q;
	logic          below_d;
	logic          hd_d;
	logic [CW-1:0] start_d;
	logic [CW-1:0] end_d;

	// compare against the broadcast request
	assign valid      = IDX_C < count;
	assign end_lt_s   = end_q < s;
	assign start_le_e = start_q <= e;
	assign below      = valid & end_lt_s;
	assign ov         = valid & ~end_lt_s & start_le_e;
	assign head       = ov & ~l_ov;
	assign hit        = valid & (start_q <= s) & ~end_lt_s;
	assign after_q    = ~below_q & ~hd_q;

	// next slot contents and flags
	always_comb begin
		start_d = start_q;
		end_d   = end_q;
		below_d = below_q;
		hd_d    = hd_q;
		ov_next = ov_q;
		case (ctl.op)
			CELL_CMP: begin
				below_d = below;
				hd_d    = head;
				ov_next = ov & ~head;
				if (ctl.ins_en && !below) begin
					if (l_below) begin
						start_d = s;
						end_d   = e;
					end else begin
						start_d = l_start;
						end_d   = l_end;
					end
				end else if (ctl.mrg_en && head) begin
					start_d = (start_q < s) ? start_q : s;
					end_d   = (end_q > e) ? end_q : e;
				end
			end
			CELL_MERGE: begin
				if (hd_q) begin
					end_d = (r_end > end_q) ? r_end : end_q;
				end else if (after_q) begin
					start_d = r_start;
					end_d   = r_end;
					ov_next = r_ov_q;
				end
			end
			default: ;
		endcase
	end

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_q <= 1'b0;
			hd_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			below_q <= below_d;
			hd_q    <= hd_d;
			ov_q    <= ov_next;
		end
	end

	// interval bounds
	always_ff @(posedge clk) begin
		start_q <= start_d;
		end_q   <= end_d;
	end

endmodule

### hdl/interval_set_insert_query_top.sv
// ----------------------------------------------------------------------------
// interval_set_insert_query_top
// Sorted set of disjoint closed intervals held in a row of cells, with
// insert-and-merge and point query.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (in_valid / in_stall): mode, range_start, range_end.
//   mode 0 inserts [range_start, range_end], mode 1 asks whether range_start
//   lies in a stored interval. Every request yields exactly one result.
// - Result channel (out_valid / out_stall): status, hit, stored_count,
//   held in an output register until taken.
// - A request is taken in an idle cycle and compared by all cells in the next;
//   the result is registered at the end of that compare cycle. An insert
//   that absorbs k > 1 stored intervals then compacts the row, removing
//   one slot per step as the tail of the row moves left one cell a cycle.
// - The request side stalls while a request is compared or compacted, so
//   the next request is taken only after the current one is finished.
// - While a finished result waits on out_stall the next request is still
//   taken; if its result is done before the output register frees, the
//   block holds it and stalls the request side until the register drains.
// - Reset empties the set (count zero) and clears the result register.
// ----------------------------------------------------------------------------
module interval_set_insert_query_top #(
	parameter int MAX_INTERVALS = 16,
	parameter int COORD_BITS    = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [isiq_pkg::COORD_W-1:0]   range_start,
	input  logic [isiq_pkg::COORD_W-1:0]   range_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [isiq_pkg::STATUS_W-1:0]  status,
	output logic                           hit,
	output logic [isiq_pkg::COUNT_W-1:0]   stored_count
);
	import isiq_pkg::*;

	localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int CNTW = $clog2(MAX_INTERVALS + 1);
	localparam logic [CNTW-1:0] FULL_C = CNTW'(MAX_INTERVALS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_MERGE,
		ST_WAIT
	} state_t;

	state_t                state_q;
	logic [CNTW-1:0]       count_q;
	logic [CNTW-1:0]       count_d;
	logic                  mode_q;
	logic [CW-1:0]         s_q;
	logic [CW-1:0]         e_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  hit_q;
	logic [COUNT_W-1:0]    stored_count_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_hit_q;

	cell_ctl_t             ctl;
	logic [CW-1:0]         c_start [MAX_INTERVALS];
	logic [CW-1:0]         c_end   [MAX_INTERVALS];
	logic [MAX_INTERVALS-1:0] c_ov_q;
	logic [MAX_INTERVALS-1:0] c_below;
	logic [MAX_INTERVALS-1:0] c_ov;
	logic [MAX_INTERVALS-1:0] c_hit;
	logic [MAX_INTERVALS-1:0] c_ov_next;

	logic                  bad_order;
	logic                  any_ov;
	logic                  any_more;
	logic                  full;
	logic                  is_insert;
	logic                  finish;
	logic                  out_free;
	logic                  out_load;
	logic [STATUS_W-1:0]   fin_status;
	logic                  fin_hit;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign hit          = hit_q;
	assign stored_count = stored_count_q;

	// request register
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q <= mode;
			s_q    <= range_start[CW-1:0];
			e_q    <= range_end[CW-1:0];
		end
	end

	// global view of the row
	assign is_insert = (mode_q == MODE_INSERT);
	assign bad_order = s_q > e_q;
	assign any_ov    = |c_ov;
	assign any_more  = |c_ov_next;
	assign full      = (count_q == FULL_C);
	assign out_free  = ~out_valid_q | ~out_stall;

	// result register takes a new result this cycle
	assign out_load = out_free & ((((state_q == ST_CMP) | (state_q == ST_MERGE)) & finish)
		| (state_q == ST_WAIT));

	// broadcast control
	always_comb begin
		ctl.op = CELL_IDLE;
		if (state_q == ST_CMP) begin
			ctl.op = CELL_CMP;
		end else if (state_q == ST_MERGE) begin
			ctl.op = CELL_MERGE;
		end
		ctl.ins_en = is_insert & ~bad_order & ~any_ov & ~full;
		ctl.mrg_en = is_insert & ~bad_order & any_ov;
	end

	// result and count for the current cycle
	always_comb begin
		fin_status = STAT_DONE;
		fin_hit    = 1'b0;
		count_d    = count_q;
		finish     = 1'b1;
		if (state_q == ST_MERGE) begin
			count_d = count_q - 1'b1;
			finish  = ~any_more;
		end else if (!is_insert) begin
			fin_hit = |c_hit;
		end else if (bad_order) begin
			fin_status = STAT_ORDER;
		end else if (ctl.ins_en) begin
			count_d = count_q + 1'b1;
		end else if (!any_ov) begin
			fin_status = STAT_FULL;
		end else begin
			finish = ~any_more;
		end
	end

	// row of cells
	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		logic [CW-1:0] l_start;
		logic [CW-1:0] l_end;
		logic          l_below;
		logic          l_ov;
		logic [CW-1:0] r_start;
		logic [CW-1:0] r_end;
		logic          r_ov_q;

		if (i == 0) begin : g_first
			assign l_start = '0;
			assign l_end   = '0;
			assign l_below = 1'b1;
			assign l_ov    = 1'b0;
		end else begin : g_mid_l
			assign l_start = c_start[i-1];
			assign l_end   = c_end[i-1];
			assign l_below = c_below[i-1];
			assign l_ov    = c_ov[i-1];
		end

		if (i == MAX_INTERVALS - 1) begin : g_last
			assign r_start = '0;
			assign r_end   = '0;
			assign r_ov_q  = 1'b0;
		end else begin : g_mid_r
			assign r_start = c_start[i+1];
			assign r_end   = c_end[i+1];
			assign r_ov_q  = c_ov_q[i+1];
		end

		isiq_cell #(
			.IDX  (i),
			.CW   (CW),
			.CNTW (CNTW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.s       (s_q),
			.e       (e_q),
			.count   (count_q),
			.l_start (l_start),
			.l_end   (l_end),
			.l_below (l_below),
			.l_ov    (l_ov),
			.r_start (r_start),
			.r_end   (r_end),
			.r_ov_q  (r_ov_q),
			.start_q (c_start[i]),
			.end_q   (c_end[i]),
			.ov_q    (c_ov_q[i]),
			.below   (c_below[i]),
			.ov      (c_ov[i]),
			.hit     (c_hit[i]),
			.ov_next (c_ov_next[i])
		);
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= STAT_DONE;
			hit_q          <= 1'b0;
			stored_count_q <= '0;
			res_status_q   <= STAT_DONE;
			res_hit_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP, ST_MERGE: begin
					count_q <= count_d;
					if (!finish) begin
						state_q <= ST_MERGE;
					end else if (out_free) begin
						status_q       <= fin_status;
						hit_q          <= fin_hit;
						stored_count_q <= COUNT_W'(count_d);
						state_q        <= ST_IDLE;
					end else begin
						res_status_q <= fin_status;
						res_hit_q    <= fin_hit;
						state_q      <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						status_q       <= res_status_q;
						hit_q          <= res_hit_q;
						stored_count_q <= COUNT_W'(count_q);
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// the set never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("interval count above capacity");

	// each compaction cycle removes exactly one slot
	a_merge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |=> (count_q == $past(count_q) - 1'b1))
		else $error("merge step did not remove one interval");

	// a query leaves the set size alone
	a_query_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && mode_q == MODE_QUERY) |=> (count_q == $past(count_q)))
		else $error("query changed the interval count");

	// compaction is only reached by an insert
	a_merge_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (mode_q == MODE_INSERT))
		else $error("merge entered for a query");

	// an insert answers hit low
	a_insert_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CMP || state_q == ST_MERGE) && mode_q == MODE_INSERT) |-> !fin_hit)
		else $error("insert reported a hit");
`endif

endmodule

### tb/sv/interval_set_checker.sv
// ----------------------------------------------------------------------------
// interval_set_checker
// Watches the request and result channels of the interval set block. Every
// accepted request runs through a local copy of the sorted interval table,
// and the predicted result is queued. Each accepted result is compared field
// by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module interval_set_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          mode,
	input  logic [isiq_pkg::COORD_W-1:0]  range_start,
	input  logic [isiq_pkg::COORD_W-1:0]  range_end,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [isiq_pkg::STATUS_W-1:0] status,
	input  logic                          hit,
	input  logic [isiq_pkg::COUNT_W-1:0]  stored_count,
	output int                            fail_count,
	output int                            pending
);
	import isiq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic                hit;
		logic [COUNT_W-1:0]  count;
	} interval_answer_t;

	// local copy of the interval table
	logic [COORD_W-1:0] lo_bound [TABLE_DEPTH];
	logic [COORD_W-1:0] hi_bound [TABLE_DEPTH];
	int                 held;

	interval_answer_t expected_answers [$];

	// one mismatch line, counted
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// apply one request to the table and work out its answer
	task automatic predict_answer(
		input  logic               op,
		input  logic [COORD_W-1:0] s,
		input  logic [COORD_W-1:0] e,
		output interval_answer_t   ans
	);
		int                 first;
		int                 past;
		int                 absorbed;
		logic [COORD_W-1:0] merged_lo;
		logic [COORD_W-1:0] merged_hi;
		ans.status = STAT_DONE;
		ans.hit    = 1'b0;
		if (op == MODE_QUERY) begin
			for (int i = 0; i < held; i++) begin
				if (lo_bound[i] <= s && s <= hi_bound[i])
					ans.hit = 1'b1;
			end
		end else if (s > e) begin
			ans.status = STAT_ORDER;
		end else begin
			// find the run of stored intervals that overlap [s, e]
			first = 0;
			while (first < held && hi_bound[first] < s)
				first++;
			past = first;
			while (past < held && lo_bound[past] <= e)
				past++;
			absorbed  = past - first;
			merged_lo = s;
			merged_hi = e;
			if (absorbed > 0) begin
				if (lo_bound[first] < merged_lo)
					merged_lo = lo_bound[first];
				if (hi_bound[past-1] > merged_hi)
					merged_hi = hi_bound[past-1];
			end
			if (held - absorbed + 1 > TABLE_DEPTH) begin
				ans.status = STAT_FULL;
			end else begin
				// open a slot, or close the gap left by absorbed entries
				if (absorbed == 0) begin
					for (int i = held; i > first; i--) begin
						lo_bound[i] = lo_bound[i-1];
						hi_bound[i] = hi_bound[i-1];
					end
				end else begin
					for (int i = first + 1; i < held - absorbed + 1; i++) begin
						lo_bound[i] = lo_bound[i+absorbed-1];
						hi_bound[i] = hi_bound[i+absorbed-1];
					end
				end
				lo_bound[first] = merged_lo;
				hi_bound[first] = merged_hi;
				held = held - absorbed + 1;
			end
		end
		ans.count = held[COUNT_W-1:0];
	endtask

	// track requests and compare results
	always @(posedge clk or negedge arst_n) begin
		interval_answer_t ans;
		interval_answer_t want;
		if (!arst_n) begin
			held       = 0;
			fail_count = 0;
			expected_answers.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result without request", 1, 0);
				end else begin
					want = expected_answers.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (hit !== want.hit)
						report_mismatch("hit", hit, want.hit);
					if (stored_count !== want.count)
						report_mismatch("stored_count", stored_count, want.count);
				end
			end
			if (in_valid && !in_stall) begin
				predict_answer(mode, range_start, range_end, ans);
				expected_answers.push_back(ans);
			end
		end
		pending = expected_answers.size();
	end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the interval set block: a directed run through merging,
// touching intervals, order errors, a full table and a full collapse, then
// random windows of inserts and queries with random idling on both sides.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import isiq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CALM_TAIL    = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = MODE_INSERT;
	logic [COORD_W-1:0]  range_start = '0;
	logic [COORD_W-1:0]  range_end = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                hit;
	logic [COUNT_W-1:0]  stored_count;

	int fail_count;
	int pending;
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;

	interval_set_insert_query_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.range_start  (range_start),
		.range_end    (range_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.stored_count (stored_count)
	);

	interval_set_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.range_start  (range_start),
		.range_end    (range_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.hit          (hit),
		.stored_count (stored_count),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side stalls in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// drive one request and hold it until accepted
	task automatic send_request(
		input logic               op,
		input logic [COORD_W-1:0] s,
		input logic [COORD_W-1:0] e
	);
		bit took;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= op;
		range_start <= s;
		range_end   <= e;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	initial begin
		logic [COORD_W-1:0] win_base;
		logic [COORD_W-1:0] s;
		logic [COORD_W-1:0] e;
		logic [COORD_W-1:0] last_lo;
		logic [COORD_W-1:0] last_hi;
		int                 win_span;
		int                 len_max;
		int                 off;
		int                 pick;
		bit                 quiet;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty query, touching intervals, multi-way merge
		send_request(MODE_QUERY, 32'd0, 32'hFFFF_FFFF);
		send_request(MODE_INSERT, 32'd10, 32'd20);
		send_request(MODE_INSERT, 32'd22, 32'd30);
		// touching end to start stays a separate interval
		send_request(MODE_INSERT, 32'd31, 32'd40);
		send_request(MODE_QUERY, 32'd30, 32'd0);
		// absorbs all three, merged end must come from the last one
		send_request(MODE_INSERT, 32'd15, 32'd35);
		send_request(MODE_INSERT, 32'd0, 32'd0);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// start after end
		send_request(MODE_INSERT, 32'd50, 32'd49);
		send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'd0);
		// fill the table, then one more disjoint insert is dropped
		for (int i = 0; i < 13; i++)
			send_request(MODE_INSERT, 32'd100 + 10 * i, 32'd102 + 10 * i);
		send_request(MODE_INSERT, 32'h8000_0000, 32'h8000_0001);
		// collapse everything into one interval
		send_request(MODE_INSERT, 32'd0, 32'hFFFF_FFFF);
		send_request(MODE_QUERY, 32'h7FFF_FFFF, 32'd5);

		// random windows of inserts and queries
		win_base = '0;
		win_span = 1000;
		len_max  = 50;
		quiet    = 1'b0;
		last_lo  = '0;
		last_hi  = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				pick = $urandom_range(0, 5);
				if (pick == 0)
					win_base = '0;
				else if (pick == 1)
					win_base = 32'hFFFF_E000;
				else
					win_base = $urandom & 32'hFFFF_0000;
				win_span = $urandom_range(100, 4000);
				len_max  = $urandom_range(0, 300);
				quiet    = ($urandom_range(0, 3) == 0);
			end
			idle_on = !quiet && (n < RANDOM_ITEMS - CALM_TAIL);
			pick = $urandom_range(0, 99);
			off  = $urandom_range(0, win_span);
			if (pick < 45) begin
				s = win_base + off;
				e = s + $urandom_range(0, len_max);
				last_lo = s;
				last_hi = e;
				send_request(MODE_INSERT, s, e);
			end else if (pick < 50) begin
				// start after end
				e = win_base + off;
				s = e + 1 + $urandom_range(0, len_max);
				send_request(MODE_INSERT, s, e);
			end else if (pick < 53) begin
				// wide insert that swallows much of the window
				s = win_base + $urandom_range(0, win_span / 4);
				e = win_base + win_span - $urandom_range(0, win_span / 4);
				send_request(MODE_INSERT, s, e);
			end else if (pick < 58) begin
				send_request(1'($urandom_range(0, 1)), $urandom, $urandom);
			end else begin
				pick = $urandom_range(0, 5);
				case (pick)
					0: s = last_lo;
					1: s = last_hi;
					2: s = last_hi + 1;
					3: s = last_lo - 1;
					default: s = win_base + off;
				endcase
				send_request(MODE_QUERY, s, $urandom);
			end
		end
		in_valid <= 1'b0;

		// drain
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
